@@ sv/acbm_pkg.sv @@
// acbm_pkg: shared constants, types and codes for the Aho-Corasick build and match unit.
// Used by acbm_ctrl, acbm_dp, the top level and acbm_chk; depends on nothing.
`timescale 1ns / 1ps
package acbm_pkg;
	localparam int MAX_STATES = 1024;
	localparam int ALPHABET   = 256;
	localparam int TAG_W      = 16;
	localparam int ST_W       = $clog2(MAX_STATES);
	localparam int CNT_W      = $clog2(MAX_STATES) + 1;
	localparam int SYM_W      = $clog2(ALPHABET);
	localparam int NT_AW      = ST_W + SYM_W;
	localparam int MC_W       = 16;
	localparam int TOT_W      = 48;
	localparam int MARK_W     = TAG_W + 1;

	localparam logic [1:0] OP_PAT  = 2'd0;
	localparam logic [1:0] OP_END  = 2'd1;
	localparam logic [1:0] OP_FIN  = 2'd2;
	localparam logic [1:0] OP_TEXT = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_PHASE = 2'd2;
	localparam logic [1:0] ST_SKIP  = 2'd3;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DECODE, S_P_RD, S_P_CHK, S_E_RD, S_E_UPD,
		S_T_RD, S_T_MC, S_T_SUM, S_FR_RD, S_FR_CHK, S_FB_POP, S_FB_S,
		S_FB_F, S_FB_MS, S_FB_MF, S_FB_RT, S_FB_RG, S_FB_UPD, S_FIN, S_OUT
	} state_t;

	typedef enum logic [4:0] {
		C_NOP, C_CLEAR, C_CAP, C_PHASE, C_SKIP_B, C_SKIP_E, C_FSTART,
		C_P_RD, C_P_CHK, C_E_RD, C_E_UPD, C_T_RD, C_T_MC, C_T_SUM,
		C_FR_RD, C_FR_CHK, C_POP, C_FB_S, C_FB_F, C_FB_MS, C_FB_MF,
		C_FB_RT, C_FB_RG, C_FB_UPD, C_FIN, C_OUT
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       fin;
		logic       ovf;
		logic       clr_last;
		logic       c_last;
		logic       q_empty;
		logic       out_free;
	} dp_status_t;
endpackage

@@ sv/acbm_ram.sv @@
// acbm_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module acbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ sv/acbm_ctrl.sv @@
// acbm_ctrl: sequencing state machine; issues one datapath command per cycle.
// Depends on acbm_pkg.
`timescale 1ns / 1ps
module acbm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  acbm_pkg::dp_status_t st,
	output acbm_pkg::cmd_t      cmd
);
	acbm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acbm_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			acbm_pkg::S_CLEAR:  if (st.clr_last) state_d = acbm_pkg::S_IDLE;
			acbm_pkg::S_IDLE:   if (in_valid) state_d = acbm_pkg::S_DECODE;
			acbm_pkg::S_DECODE: begin
				if (st.op == acbm_pkg::OP_TEXT) begin
					state_d = st.fin ? acbm_pkg::S_T_RD : acbm_pkg::S_OUT;
				end else if (st.fin) begin
					state_d = acbm_pkg::S_OUT;
				end else if (st.op == acbm_pkg::OP_PAT) begin
					state_d = st.ovf ? acbm_pkg::S_OUT : acbm_pkg::S_P_RD;
				end else if (st.op == acbm_pkg::OP_END) begin
					state_d = st.ovf ? acbm_pkg::S_OUT : acbm_pkg::S_E_RD;
				end else begin
					state_d = acbm_pkg::S_FR_RD;
				end
			end
			acbm_pkg::S_P_RD:   state_d = acbm_pkg::S_P_CHK;
			acbm_pkg::S_P_CHK:  state_d = acbm_pkg::S_OUT;
			acbm_pkg::S_E_RD:   state_d = acbm_pkg::S_E_UPD;
			acbm_pkg::S_E_UPD:  state_d = acbm_pkg::S_OUT;
			acbm_pkg::S_T_RD:   state_d = acbm_pkg::S_T_MC;
			acbm_pkg::S_T_MC:   state_d = acbm_pkg::S_T_SUM;
			acbm_pkg::S_T_SUM:  state_d = acbm_pkg::S_OUT;
			acbm_pkg::S_FR_RD:  state_d = acbm_pkg::S_FR_CHK;
			acbm_pkg::S_FR_CHK: state_d = st.c_last ? acbm_pkg::S_FB_POP : acbm_pkg::S_FR_RD;
			acbm_pkg::S_FB_POP: state_d = st.q_empty ? acbm_pkg::S_FIN : acbm_pkg::S_FB_S;
			acbm_pkg::S_FB_S:   state_d = acbm_pkg::S_FB_F;
			acbm_pkg::S_FB_F:   state_d = acbm_pkg::S_FB_MS;
			acbm_pkg::S_FB_MS:  state_d = acbm_pkg::S_FB_MF;
			acbm_pkg::S_FB_MF:  state_d = acbm_pkg::S_FB_RT;
			acbm_pkg::S_FB_RT:  state_d = acbm_pkg::S_FB_RG;
			acbm_pkg::S_FB_RG:  state_d = acbm_pkg::S_FB_UPD;
			acbm_pkg::S_FB_UPD: state_d = st.c_last ? acbm_pkg::S_FB_POP : acbm_pkg::S_FB_RT;
			acbm_pkg::S_FIN:    state_d = acbm_pkg::S_OUT;
			acbm_pkg::S_OUT:    if (st.out_free) state_d = acbm_pkg::S_IDLE;
			default:            state_d = acbm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = acbm_pkg::C_NOP;
		case (state_q)
			acbm_pkg::S_CLEAR: cmd = acbm_pkg::C_CLEAR;
			acbm_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd = acbm_pkg::C_CAP;
			end
			acbm_pkg::S_DECODE: begin
				if (st.op == acbm_pkg::OP_TEXT) begin
					if (!st.fin) cmd = acbm_pkg::C_PHASE;
				end else if (st.fin) begin
					cmd = acbm_pkg::C_PHASE;
				end else if (st.op == acbm_pkg::OP_PAT) begin
					if (st.ovf) cmd = acbm_pkg::C_SKIP_B;
				end else if (st.op == acbm_pkg::OP_END) begin
					if (st.ovf) cmd = acbm_pkg::C_SKIP_E;
				end else begin
					cmd = acbm_pkg::C_FSTART;
				end
			end
			acbm_pkg::S_P_RD:   cmd = acbm_pkg::C_P_RD;
			acbm_pkg::S_P_CHK:  cmd = acbm_pkg::C_P_CHK;
			acbm_pkg::S_E_RD:   cmd = acbm_pkg::C_E_RD;
			acbm_pkg::S_E_UPD:  cmd = acbm_pkg::C_E_UPD;
			acbm_pkg::S_T_RD:   cmd = acbm_pkg::C_T_RD;
			acbm_pkg::S_T_MC:   cmd = acbm_pkg::C_T_MC;
			acbm_pkg::S_T_SUM:  cmd = acbm_pkg::C_T_SUM;
			acbm_pkg::S_FR_RD:  cmd = acbm_pkg::C_FR_RD;
			acbm_pkg::S_FR_CHK: cmd = acbm_pkg::C_FR_CHK;
			acbm_pkg::S_FB_POP: if (!st.q_empty) cmd = acbm_pkg::C_POP;
			acbm_pkg::S_FB_S:   cmd = acbm_pkg::C_FB_S;
			acbm_pkg::S_FB_F:   cmd = acbm_pkg::C_FB_F;
			acbm_pkg::S_FB_MS:  cmd = acbm_pkg::C_FB_MS;
			acbm_pkg::S_FB_MF:  cmd = acbm_pkg::C_FB_MF;
			acbm_pkg::S_FB_RT:  cmd = acbm_pkg::C_FB_RT;
			acbm_pkg::S_FB_RG:  cmd = acbm_pkg::C_FB_RG;
			acbm_pkg::S_FB_UPD: cmd = acbm_pkg::C_FB_UPD;
			acbm_pkg::S_FIN:    cmd = acbm_pkg::C_FIN;
			acbm_pkg::S_OUT:    if (st.out_free) cmd = acbm_pkg::C_OUT;
			default:            cmd = acbm_pkg::C_NOP;
		endcase
	end
endmodule

@@ sv/acbm_dp.sv @@
// acbm_dp: datapath - transition table, counts, tags, failure links, BFS queue,
// build/search registers and the output register. Depends on acbm_pkg, acbm_ram.
`timescale 1ns / 1ps
module acbm_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  acbm_pkg::cmd_t       cmd,
	output acbm_pkg::dp_status_t st,
	input  logic [23:0]          in_data,
	input  logic [1:0]           in_user,
	input  logic                 in_last,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [87:0]          out_data,
	output logic [1:0]           out_user,
	output logic                 out_last
);
	localparam int ST_W  = acbm_pkg::ST_W;
	localparam int CNT_W = acbm_pkg::CNT_W;
	localparam int SYM_W = acbm_pkg::SYM_W;
	localparam int NT_AW = acbm_pkg::NT_AW;
	localparam int MC_W  = acbm_pkg::MC_W;
	localparam int TOT_W = acbm_pkg::TOT_W;
	localparam int MK_W  = acbm_pkg::MARK_W;

	logic [1:0]              op_q;
	logic [SYM_W-1:0]        sym_q;
	logic [acbm_pkg::TAG_W-1:0] tag_q;
	logic                    last_q;
	logic [CNT_W-1:0]        cnt_q, head_q, tail_q;
	logic [ST_W-1:0]         cur_q, srch_q, s_q, f_q, t_q;
	logic                    ovf_q, fin_q;
	logic [TOT_W-1:0]        tot_q;
	logic [SYM_W-1:0]        c_q;
	logic [NT_AW-1:0]        clr_q;
	logic [MC_W-1:0]         mcs_q, bm_q;
	logic [1:0]              stat_q;
	logic                    done_q;
	logic                    ov_q;
	logic [87:0]             od_q;
	logic [1:0]              ou_q;
	logic                    ol_q;

	logic                    nt_we, mc_we, tg_we, fl_we, qu_we;
	logic [NT_AW-1:0]        nt_wa, nt_ra;
	logic [ST_W-1:0]         nt_wd, nt_rd;
	logic [ST_W-1:0]         mc_wa, mc_ra;
	logic [MC_W-1:0]         mc_wd, mc_rd;
	logic [MK_W-1:0]         tg_wd, tg_rd, mark;
	logic [ST_W-1:0]         fl_wa, fl_wd, fl_rd;
	logic [ST_W-1:0]         qu_wa, qu_ra, qu_rd;
	logic [MC_W:0]           mc_inc, mc_add;
	logic [TOT_W:0]          tot_add;
	logic                    out_free;

	assign mark     = {1'b1, tag_q};
	assign mc_inc   = {1'b0, mc_rd} + {{MC_W{1'b0}}, 1'b1};
	assign mc_add   = {1'b0, mcs_q} + {1'b0, mc_rd};
	assign tot_add  = {1'b0, tot_q} + {{(TOT_W-MC_W+1){1'b0}}, mc_rd};
	assign out_free = !ov_q || out_ready;

	always_comb begin
		nt_we = 1'b0; nt_wa = {cur_q, sym_q}; nt_wd = cnt_q[ST_W-1:0];
		nt_ra = {cur_q, sym_q};
		mc_we = 1'b0; mc_wa = cur_q; mc_wd = mc_inc[MC_W-1:0]; mc_ra = cur_q;
		tg_we = 1'b0; tg_wd = mark;
		fl_we = 1'b0; fl_wa = nt_rd; fl_wd = '0;
		qu_we = 1'b0; qu_wa = tail_q[ST_W-1:0]; qu_ra = head_q[ST_W-1:0];
		case (cmd)
			acbm_pkg::C_CLEAR: begin
				nt_we = 1'b1; nt_wa = clr_q; nt_wd = '0;
				mc_we = 1'b1; mc_wa = clr_q[ST_W-1:0]; mc_wd = '0;
				tg_we = 1'b1; tg_wd = '0;
			end
			acbm_pkg::C_P_CHK: nt_we = (nt_rd == '0) && (cnt_q < CNT_W'(acbm_pkg::MAX_STATES));
			acbm_pkg::C_E_UPD: begin
				tg_we = (tg_rd != mark);
				mc_we = (tg_rd != mark);
				if (mc_inc[MC_W]) mc_wd = '1;
			end
			acbm_pkg::C_T_RD:  nt_ra = {srch_q, sym_q};
			acbm_pkg::C_T_MC:  mc_ra = nt_rd;
			acbm_pkg::C_FR_RD: nt_ra = {{ST_W{1'b0}}, c_q};
			acbm_pkg::C_FR_CHK: begin
				fl_we = (nt_rd != '0);
				qu_we = (nt_rd != '0);
			end
			acbm_pkg::C_FB_F:  mc_ra = s_q;
			acbm_pkg::C_FB_MS: mc_ra = f_q;
			acbm_pkg::C_FB_MF: begin
				mc_we = 1'b1; mc_wa = s_q;
				mc_wd = mc_add[MC_W] ? '1 : mc_add[MC_W-1:0];
			end
			acbm_pkg::C_FB_RT: nt_ra = {s_q, c_q};
			acbm_pkg::C_FB_RG: nt_ra = {f_q, c_q};
			acbm_pkg::C_FB_UPD: begin
				if (t_q != '0) begin
					fl_we = (tail_q < CNT_W'(acbm_pkg::MAX_STATES));
					qu_we = fl_we;
					fl_wa = t_q; fl_wd = nt_rd;
				end else begin
					nt_we = 1'b1; nt_wa = {s_q, c_q}; nt_wd = nt_rd;
				end
			end
			default: ;
		endcase
	end

	acbm_ram #(.WIDTH(ST_W), .DEPTH(acbm_pkg::MAX_STATES * acbm_pkg::ALPHABET)) u_next (
		.clk(clk), .we(nt_we), .waddr(nt_wa), .wdata(nt_wd), .raddr(nt_ra), .rdata(nt_rd));
	acbm_ram #(.WIDTH(MC_W), .DEPTH(acbm_pkg::MAX_STATES)) u_mcnt (
		.clk(clk), .we(mc_we), .waddr(mc_wa), .wdata(mc_wd), .raddr(mc_ra), .rdata(mc_rd));
	acbm_ram #(.WIDTH(MK_W), .DEPTH(acbm_pkg::MAX_STATES)) u_tag (
		.clk(clk), .we(tg_we), .waddr(mc_wa), .wdata(tg_wd), .raddr(cur_q), .rdata(tg_rd));
	acbm_ram #(.WIDTH(ST_W), .DEPTH(acbm_pkg::MAX_STATES)) u_fail (
		.clk(clk), .we(fl_we), .waddr(fl_wa), .wdata(fl_wd), .raddr(qu_rd), .rdata(fl_rd));
	acbm_ram #(.WIDTH(ST_W), .DEPTH(acbm_pkg::MAX_STATES)) u_queue (
		.clk(clk), .we(qu_we), .waddr(qu_wa), .wdata(fl_wa), .raddr(qu_ra), .rdata(qu_rd));

	always_ff @(posedge clk) begin
		case (cmd)
			acbm_pkg::C_CAP: begin
				op_q   <= in_user;
				sym_q  <= in_data[SYM_W-1:0];
				tag_q  <= in_data[8 +: acbm_pkg::TAG_W];
				last_q <= in_last;
			end
			acbm_pkg::C_FB_S:  s_q <= qu_rd;
			acbm_pkg::C_FB_F:  f_q <= fl_rd;
			acbm_pkg::C_FB_MS: mcs_q <= mc_rd;
			acbm_pkg::C_FB_RG: t_q <= nt_rd;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= CNT_W'(1);
			cur_q  <= '0;
			srch_q <= '0;
			ovf_q  <= 1'b0;
			fin_q  <= 1'b0;
			tot_q  <= '0;
			head_q <= '0;
			tail_q <= '0;
			c_q    <= '0;
			clr_q  <= '0;
			stat_q <= acbm_pkg::ST_OK;
			bm_q   <= '0;
			done_q <= 1'b0;
			ov_q   <= 1'b0;
			od_q   <= '0;
			ou_q   <= '0;
			ol_q   <= 1'b0;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			case (cmd)
				acbm_pkg::C_CLEAR: clr_q <= clr_q + NT_AW'(1);
				acbm_pkg::C_CAP: begin
					stat_q <= acbm_pkg::ST_OK;
					bm_q   <= '0;
					done_q <= 1'b0;
				end
				acbm_pkg::C_PHASE:  stat_q <= acbm_pkg::ST_PHASE;
				acbm_pkg::C_SKIP_B: stat_q <= acbm_pkg::ST_SKIP;
				acbm_pkg::C_SKIP_E: begin
					stat_q <= acbm_pkg::ST_SKIP;
					ovf_q  <= 1'b0;
					cur_q  <= '0;
				end
				acbm_pkg::C_FSTART: begin
					c_q    <= '0;
					head_q <= '0;
					tail_q <= '0;
				end
				acbm_pkg::C_P_CHK: begin
					if (nt_rd != '0) begin
						cur_q <= nt_rd;
					end else if (cnt_q >= CNT_W'(acbm_pkg::MAX_STATES)) begin
						ovf_q  <= 1'b1;
						stat_q <= acbm_pkg::ST_FULL;
					end else begin
						cur_q <= cnt_q[ST_W-1:0];
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				acbm_pkg::C_E_UPD: cur_q <= '0;
				acbm_pkg::C_T_MC:  srch_q <= nt_rd;
				acbm_pkg::C_T_SUM: begin
					bm_q   <= mc_rd;
					tot_q  <= tot_add[TOT_W] ? '1 : tot_add[TOT_W-1:0];
					done_q <= last_q;
				end
				acbm_pkg::C_FR_CHK: begin
					c_q <= c_q + SYM_W'(1);
					if (qu_we) tail_q <= tail_q + CNT_W'(1);
				end
				acbm_pkg::C_FB_S:  head_q <= head_q + CNT_W'(1);
				acbm_pkg::C_FB_MF: c_q <= '0;
				acbm_pkg::C_FB_UPD: begin
					c_q <= c_q + SYM_W'(1);
					if (qu_we) tail_q <= tail_q + CNT_W'(1);
				end
				acbm_pkg::C_FIN: begin
					fin_q  <= 1'b1;
					cur_q  <= '0;
					ovf_q  <= 1'b0;
					srch_q <= '0;
					tot_q  <= '0;
				end
				acbm_pkg::C_OUT: begin
					ov_q <= 1'b1;
					od_q <= {3'b000, cnt_q, (fin_q ? srch_q : cur_q), tot_q, bm_q};
					ou_q <= stat_q;
					ol_q <= done_q;
					if (done_q) begin
						tot_q  <= '0;
						srch_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign st.op       = op_q;
	assign st.fin      = fin_q;
	assign st.ovf      = ovf_q;
	assign st.clr_last = (clr_q == '1);
	assign st.c_last   = (c_q == '1);
	assign st.q_empty  = (head_q == tail_q);
	assign st.out_free = out_free;

	assign out_valid = ov_q;
	assign out_data  = od_q;
	assign out_user  = ou_q;
	assign out_last  = ol_q;
endmodule

@@ sv/aho_corasick_build_and_match_unit.sv @@
// Top level of the Aho-Corasick build and match unit: controller plus datapath.
// Depends on acbm_pkg, acbm_ctrl, acbm_dp (and through it acbm_ram).
//
//  channel | dir | tdata                                         | tuser  | tlast
//  s_*     | in  | [7:0] data_byte, [23:8] pattern_tag           | op     | last_text
//  m_*     | out | [15:0] byte_matches, [63:16] running_total,   | status | text_done
//          |     | [73:64] dfa_state, [84:74] states_used        |        |
//
// One item at a time: no beat is taken until the last one's result is registered.
// Each table has a single read port, so an item steps through its read and update states.
// Finalize walks the root's children, then pops each trie state and visits all 256 symbols.
// After reset a clearing pass zeroes the 262144-entry transition table; no beat
// is taken until it ends. A stalled output holds the next item until the output frees.
`timescale 1ns / 1ps
module aho_corasick_build_and_match_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // data_byte, pattern_tag
	input  logic [1:0]  s_tuser,   // op
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // byte_matches, running_total, dfa_state, states_used
	output logic [1:0]  m_tuser,   // status
	output logic        m_tlast
);
	acbm_pkg::cmd_t       cmd;
	acbm_pkg::dp_status_t st;

	acbm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.st(st), .cmd(cmd));

	acbm_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.in_data(s_tdata), .in_user(s_tuser), .in_last(s_tlast),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata),
		.out_user(m_tuser), .out_last(m_tlast));
endmodule

@@ sv/acbm_chk.sv @@
// acbm_chk: port-level checks for the Aho-Corasick unit, bound to the top level.
// Depends on acbm_pkg.
`timescale 1ns / 1ps
module acbm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");
	a_done_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == acbm_pkg::ST_OK)
		else $error("text end on a failed beat");
	a_phase_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == acbm_pkg::ST_PHASE |-> m_tdata[15:0] == 16'd0 && !m_tlast)
		else $error("wrong-phase beat carries matches");
	a_used: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[84:74] != 11'd0 && m_tdata[84:74] <= 11'd1024)
		else $error("states_used out of range");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second beat taken while busy");
endmodule

bind aho_corasick_build_and_match_unit acbm_chk u_acbm_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
	.m_tuser(m_tuser), .m_tlast(m_tlast));

@@ tb/tb_top.sv @@
// tb_top: stream-level testbench for aho_corasick_build_and_match_unit.
// Builds a trie up to the full table, finalizes it, scans text, and checks every result beat
// against an in-bench automaton. Depends on acbm_pkg and the unit.
`timescale 1ns / 1ps
module tb_top;
	typedef struct {
		logic [1:0]  op;
		logic [7:0]  b;
		logic [15:0] tag;
		logic        last;
	} item_t;

	typedef struct {
		logic [1:0]  status;
		logic [15:0] bm;
		logic [47:0] total;
		logic [9:0]  st;
		logic [10:0] used;
		logic        done;
	} res_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        s_tlast = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [87:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	aho_corasick_build_and_match_unit dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// automaton copy
	int          ac_next [acbm_pkg::MAX_STATES*acbm_pkg::ALPHABET];
	int          ac_cnt [acbm_pkg::MAX_STATES];
	logic [16:0] ac_mark [acbm_pkg::MAX_STATES];
	int          ac_fail [acbm_pkg::MAX_STATES];
	int          ac_bfs [acbm_pkg::MAX_STATES];
	int          n_states, cursor, cur_st;
	bit          ovf, fin;
	logic [48:0] total;

	item_t items[$];
	res_t  expected[$];
	int    errors = 0, n_checked = 0, n_matches = 0, n_texts = 0;

	function automatic int sat16(int a, int b);
		return (a + b > 65535) ? 65535 : a + b;
	endfunction

	function automatic void build_table();
		int head, tail, s, f, t, g;
		head = 0;
		tail = 0;
		for (int c = 0; c < acbm_pkg::ALPHABET; c++) begin
			t = ac_next[c];
			if (t != 0 && tail < acbm_pkg::MAX_STATES) begin
				ac_fail[t] = 0;
				ac_bfs[tail++] = t;
			end
		end
		while (head < tail) begin
			s = ac_bfs[head++];
			f = ac_fail[s];
			ac_cnt[s] = sat16(ac_cnt[s], ac_cnt[f]);
			for (int c = 0; c < acbm_pkg::ALPHABET; c++) begin
				t = ac_next[s*acbm_pkg::ALPHABET + c];
				g = ac_next[f*acbm_pkg::ALPHABET + c];
				if (t != 0) begin
					if (tail < acbm_pkg::MAX_STATES) begin
						ac_fail[t] = g;
						ac_bfs[tail++] = t;
					end
				end else
					ac_next[s*acbm_pkg::ALPHABET + c] = g;
			end
		end
	endfunction

	function automatic void push_item(logic [1:0] op, logic [7:0] b, logic [15:0] tag,
			logic last);
		item_t it;
		res_t r;
		int e;
		it = '{op, b, tag, last};
		r = '{acbm_pkg::ST_OK, 16'd0, 48'd0, 10'd0, 11'd0, 1'b0};
		if (op == acbm_pkg::OP_TEXT) begin
			if (!fin)
				r.status = acbm_pkg::ST_PHASE;
			else begin
				cur_st = ac_next[cur_st*acbm_pkg::ALPHABET + b];
				r.bm = 16'(ac_cnt[cur_st]);
				total = total + 49'(ac_cnt[cur_st]);
				if (total > 49'hFFFF_FFFF_FFFF) total = 49'hFFFF_FFFF_FFFF;
				if (r.bm != 0) n_matches++;
			end
		end else if (fin)
			r.status = acbm_pkg::ST_PHASE;
		else if (op == acbm_pkg::OP_PAT) begin
			if (ovf)
				r.status = acbm_pkg::ST_SKIP;
			else begin
				e = cursor*acbm_pkg::ALPHABET + b;
				if (ac_next[e] == 0) begin
					if (n_states >= acbm_pkg::MAX_STATES) begin
						ovf = 1;
						r.status = acbm_pkg::ST_FULL;
					end else
						ac_next[e] = n_states++;
				end
				if (r.status == acbm_pkg::ST_OK) cursor = ac_next[e];
			end
		end else if (op == acbm_pkg::OP_END) begin
			if (ovf) begin
				r.status = acbm_pkg::ST_SKIP;
				ovf = 0;
			end else if (ac_mark[cursor] != {1'b1, tag}) begin
				ac_mark[cursor] = {1'b1, tag};
				ac_cnt[cursor] = sat16(ac_cnt[cursor], 1);
			end
			cursor = 0;
		end else begin
			build_table();
			fin = 1;
			cursor = 0;
			ovf = 0;
			cur_st = 0;
			total = 0;
		end
		r.st = 10'(fin ? cur_st : cursor);
		r.total = total[47:0];
		r.used = 11'(n_states);
		if (op == acbm_pkg::OP_TEXT && r.status == acbm_pkg::ST_OK && last) begin
			r.done = 1;
			total = 0;
			cur_st = 0;
			n_texts++;
		end
		items.push_back(it);
		expected.push_back(r);
	endfunction

	function automatic void push_pattern(int len, bit narrow);
		for (int i = 0; i < len; i++)
			push_item(acbm_pkg::OP_PAT,
				narrow ? 8'(8'h61 + $urandom_range(0, 3)) : 8'($urandom_range(0, 255)),
				16'd0, 1'($urandom_range(0, 1)));
		push_item(acbm_pkg::OP_END, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
			1'($urandom_range(0, 1)));
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// driver
	int idx = 0, in_gap = 0, quiet = 0;
	always @(posedge clk) begin
		int nidx, g;
		nidx = idx;
		g = in_gap;
		if (s_tvalid && s_tready) nidx++;
		if (arst_n && !(s_tvalid && !s_tready)) begin
			if (g > 0) begin
				g--;
				s_tvalid <= 0;
			end else if (nidx < items.size()) begin
				s_tvalid <= 1;
				s_tdata <= {items[nidx].tag, items[nidx].b};
				s_tuser <= items[nidx].op;
				s_tlast <= items[nidx].last;
				g = (nidx % 400 < 100) ? 0 : pick_gap();
			end else
				s_tvalid <= 0;
		end
		idx = nidx;
		in_gap = g;
	end

	// receiver and checker
	int out_gap = 0, hold = 0;
	bit held = 0;
	always @(posedge clk) begin
		res_t r;
		logic rdy;
		if (m_tvalid && m_tready) begin
			if (expected.size() == 0) begin
				$display("%0t: unexpected beat tuser=%0d tdata=%h", $time, m_tuser, m_tdata);
				errors++;
			end else begin
				r = expected.pop_front();
				if (m_tuser !== r.status || m_tdata[15:0] !== r.bm ||
				    m_tdata[63:16] !== r.total || m_tdata[73:64] !== r.st ||
				    m_tdata[84:74] !== r.used || m_tdata[87:85] !== 3'd0 ||
				    m_tlast !== r.done) begin
					$display("%0t: beat %0d exp st=%0d bm=%0d tot=%0d q=%0d used=%0d done=%0d",
						$time, n_checked, r.status, r.bm, r.total, r.st, r.used, r.done);
					$display("%0t: beat %0d act st=%0d bm=%0d tot=%0d q=%0d used=%0d done=%0d",
						$time, n_checked, m_tuser, m_tdata[15:0], m_tdata[63:16],
						m_tdata[73:64], m_tdata[84:74], m_tlast);
					errors++;
				end
			end
			n_checked++;
		end
		if (!held && n_checked == 60) begin
			held = 1;
			hold = 3000;
		end
		if (hold > 0) begin
			hold--;
			rdy = 0;
		end else if (out_gap > 0) begin
			out_gap--;
			rdy = 0;
		end else begin
			rdy = 1;
			if (n_checked % 300 > 80) out_gap = pick_gap();
		end
		m_tready <= rdy;
	end

	// watchdog
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else if (++idle_cycles >= 3000000) begin
			$display("watchdog: no beat for %0d cycles", idle_cycles);
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < acbm_pkg::MAX_STATES*acbm_pkg::ALPHABET; i++) ac_next[i] = 0;
		for (int i = 0; i < acbm_pkg::MAX_STATES; i++) begin
			ac_cnt[i] = 0;
			ac_mark[i] = '0;
			ac_fail[i] = 0;
		end
		n_states = 1;
		cursor = 0;
		cur_st = 0;
		ovf = 0;
		fin = 0;
		total = 0;

		// directed
		push_item(acbm_pkg::OP_TEXT, 8'h61, 16'hFFFF, 1);
		push_item(acbm_pkg::OP_END, 8'h00, 16'h0000, 0);
		push_item(acbm_pkg::OP_END, 8'hFF, 16'h0000, 1);
		push_item(acbm_pkg::OP_END, 8'h00, 16'hFFFF, 0);
		push_item(acbm_pkg::OP_PAT, 8'h00, 16'hFFFF, 1);
		push_item(acbm_pkg::OP_PAT, 8'hFF, 16'h0000, 0);
		push_item(acbm_pkg::OP_END, 8'h00, 16'h0001, 0);
		push_item(acbm_pkg::OP_PAT, 8'h00, 16'h0000, 0);
		push_item(acbm_pkg::OP_PAT, 8'hFF, 16'h0000, 0);
		push_item(acbm_pkg::OP_END, 8'h00, 16'h0001, 0);
		push_item(acbm_pkg::OP_PAT, 8'h00, 16'h0000, 0);
		push_item(acbm_pkg::OP_PAT, 8'hFF, 16'h0000, 0);
		push_item(acbm_pkg::OP_END, 8'h00, 16'h0002, 0);

		for (int p = 0; p < 40; p++) push_pattern($urandom_range(1, 4), 1);
		while (n_states < acbm_pkg::MAX_STATES) push_pattern($urandom_range(8, 40), 0);
		push_pattern(3, 0);
		for (int p = 0; p < 10; p++) push_pattern($urandom_range(1, 4), 1);
		push_pattern(5, 0);
		push_item(acbm_pkg::OP_PAT, 8'h62, 16'h1234, 0);
		push_item(acbm_pkg::OP_PAT, 8'h63, 16'h4321, 1);
		push_item(acbm_pkg::OP_FIN, 8'hA5, 16'h5A5A, 1);

		push_item(acbm_pkg::OP_PAT, 8'h61, 16'h0000, 0);
		push_item(acbm_pkg::OP_END, 8'h00, 16'h0007, 0);
		push_item(acbm_pkg::OP_FIN, 8'h00, 16'h0000, 0);
		for (int i = 0; i < 480; i++) begin
			if ($urandom_range(0, 49) == 0)
				push_item(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
					16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
			else
				push_item(acbm_pkg::OP_TEXT, ($urandom_range(0, 9) == 0)
					? 8'($urandom_range(0, 255)) : 8'(8'h61 + $urandom_range(0, 3)),
					16'($urandom_range(0, 65535)), $urandom_range(0, 29) == 0);
		end
		push_item(acbm_pkg::OP_TEXT, 8'h61, 16'h0000, 1);

		repeat (12) @(posedge clk);
		arst_n <= 1;
		wait (idx == items.size() && expected.size() == 0);
		repeat (50) @(posedge clk);
		$display("ran %0d beats: full trie of %0d states with overflow and skips, finalize,",
			items.size(), n_states);
		$display("then %0d texts with %0d matching bytes, phase errors mixed in", n_texts, n_matches);
		if (errors == 0 && expected.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule
